/* rtl/hlc_pkg.sv */
// package for the homogeneous line clipper: types, constants and plane helpers
package hlc_pkg;

  localparam int NUM_PLANES    = 6;
  localparam int NUM_COMP      = 5;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

  localparam logic [2:0] COMP_X     = 3'd0;
  localparam logic [2:0] COMP_Y     = 3'd1;
  localparam logic [2:0] COMP_Z     = 3'd2;
  localparam logic [2:0] COMP_W     = 3'd3;
  localparam logic [2:0] COMP_LEVEL = 3'd4;

  localparam logic [2:0] PLANE_LEFT   = 3'd0;
  localparam logic [2:0] PLANE_RIGHT  = 3'd1;
  localparam logic [2:0] PLANE_BOTTOM = 3'd2;
  localparam logic [2:0] PLANE_TOP    = 3'd3;
  localparam logic [2:0] PLANE_FAR    = 3'd4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic [15:0]        level;
  } vtx_t;

  typedef struct packed {
    vtx_t       a;
    vtx_t       b;
    logic [5:0] ca;
    logic [5:0] cb;
  } seg_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] quo;
    logic [33:0] sum;
    logic        lsb;
  } lane_t;

  typedef struct packed {
    logic        q;
    logic [33:0] rem;
  } step_t;

  typedef struct packed {
    logic visible;
    vtx_t a;
    vtx_t b;
  } res_t;

  function automatic logic signed [33:0] plane_dist(input logic [2:0] p, input vtx_t v);
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic signed [33:0] w;
    x = 34'(v.x);
    y = 34'(v.y);
    z = 34'(v.z);
    w = 34'(v.w);
    case (p)
      PLANE_LEFT:   return x + w;
      PLANE_RIGHT:  return w - x;
      PLANE_BOTTOM: return y + w;
      PLANE_TOP:    return w - y;
      PLANE_FAR:    return w - z;
      default:      return z;
    endcase
  endfunction

  function automatic logic [5:0] outcode(input vtx_t v);
    logic [5:0] code;
    logic signed [33:0] d;
    code = '0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      d = plane_dist(3'(i), v);
      code[i] = d[33];
    end
    return code;
  endfunction

  function automatic logic signed [32:0] vtx_comp(input vtx_t v, input logic [2:0] c);
    case (c)
      COMP_X:  return 33'(v.x);
      COMP_Y:  return 33'(v.y);
      COMP_Z:  return 33'(v.z);
      COMP_W:  return 33'(v.w);
      default: return $signed({17'b0, v.level});
    endcase
  endfunction

  // one restoring division step
  function automatic step_t div_step(input logic [33:0] rem, input logic [33:0] sum,
                                     input logic b);
    step_t s;
    logic [34:0] t;
    logic [34:0] d;
    t = {rem, b};
    d = t - {1'b0, sum};
    if (t >= {1'b0, sum}) begin
      s.q   = 1'b1;
      s.rem = d[33:0];
    end else begin
      s.q   = 1'b0;
      s.rem = t[33:0];
    end
    return s;
  endfunction

endpackage

/* rtl/hlc_if.sv */
// valid/ready channel interfaces for segments and clipped results
interface hlc_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] az;
  logic signed [31:0] aw;
  logic [15:0]        a_level;
  logic signed [31:0] bx;
  logic signed [31:0] by;
  logic signed [31:0] bz;
  logic signed [31:0] bw;
  logic [15:0]        b_level;

  modport source (output valid, ax, ay, az, aw, a_level, bx, by, bz, bw, b_level,
                  input ready);
  modport sink (input valid, ax, ay, az, aw, a_level, bx, by, bz, bw, b_level,
                output ready);
endinterface

interface hlc_res_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] out_ax;
  logic signed [31:0] out_ay;
  logic signed [31:0] out_az;
  logic signed [31:0] out_aw;
  logic [15:0]        out_a_level;
  logic signed [31:0] out_bx;
  logic signed [31:0] out_by;
  logic signed [31:0] out_bz;
  logic signed [31:0] out_bw;
  logic [15:0]        out_b_level;

  modport source (output valid, visible, out_ax, out_ay, out_az, out_aw, out_a_level,
                  out_bx, out_by, out_bz, out_bw, out_b_level, input ready);
  modport sink (input valid, visible, out_ax, out_ay, out_az, out_aw, out_a_level,
                out_bx, out_by, out_bz, out_bw, out_b_level, output ready);
endinterface

/* rtl/homogeneous_line_clipper.sv */
// top level of the homogeneous clip space line clipper
// throughput: one segment per cycle unless a waiting result is held; the 16-stage six-lane divider sets the depth
// the whole pipeline advances together and holds while a result waits
// reset clears every valid bit; payload registers are not reset
module homogeneous_line_clipper (
  input  logic      clk,
  input  logic      rst,
  hlc_seg_if.sink   seg,
  hlc_res_if.source res
);

  logic                 en;
  hlc_pkg::vtx_t        in_a;
  hlc_pkg::vtx_t        in_b;

  logic                 su_valid;
  hlc_pkg::seg_t        su_seg;
  hlc_pkg::lane_t [5:0] su_lane;

  logic                 dv_valid;
  hlc_pkg::seg_t        dv_seg;
  hlc_pkg::lane_t [5:0] dv_lane;

  logic                 ip_valid;
  hlc_pkg::seg_t        ip_seg;
  hlc_pkg::vtx_t [5:0]  ip_pt;
  logic [5:0]           ip_ok;

  logic                 sel_valid;
  hlc_pkg::res_t        sel_res;

  assign en        = !sel_valid || res.ready;
  assign seg.ready = en;

  assign in_a = '{x: seg.ax, y: seg.ay, z: seg.az, w: seg.aw, level: seg.a_level};
  assign in_b = '{x: seg.bx, y: seg.by, z: seg.bz, w: seg.bw, level: seg.b_level};

  hlc_setup u_setup (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(seg.valid), .in_a(in_a), .in_b(in_b),
    .out_valid(su_valid), .out_seg(su_seg), .out_lane(su_lane)
  );

  hlc_divider u_divider (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(su_valid), .in_seg(su_seg), .in_lane(su_lane),
    .out_valid(dv_valid), .out_seg(dv_seg), .out_lane(dv_lane)
  );

  hlc_interp u_interp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(dv_valid), .in_seg(dv_seg), .in_lane(dv_lane),
    .out_valid(ip_valid), .out_seg(ip_seg), .out_pt(ip_pt), .out_ok(ip_ok)
  );

  hlc_select u_select (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(ip_valid), .in_seg(ip_seg), .in_pt(ip_pt), .in_ok(ip_ok),
    .out_valid(sel_valid), .out_res(sel_res)
  );

  assign res.valid       = sel_valid;
  assign res.visible     = sel_res.visible;
  assign res.out_ax      = sel_res.a.x;
  assign res.out_ay      = sel_res.a.y;
  assign res.out_az      = sel_res.a.z;
  assign res.out_aw      = sel_res.a.w;
  assign res.out_a_level = sel_res.a.level;
  assign res.out_bx      = sel_res.b.x;
  assign res.out_by      = sel_res.b.y;
  assign res.out_bz      = sel_res.b.z;
  assign res.out_bw      = sel_res.b.w;
  assign res.out_b_level = sel_res.b.level;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

endmodule

/* rtl/hlc_setup.sv */
// outcodes, plane distance magnitudes and divider operands for each plane
module hlc_setup (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  hlc_pkg::vtx_t         in_a,
  input  hlc_pkg::vtx_t         in_b,
  output logic                  out_valid,
  output hlc_pkg::seg_t         out_seg,
  output hlc_pkg::lane_t [5:0]  out_lane
);

  hlc_pkg::lane_t [5:0] lane_next;
  logic signed [33:0]   da;
  logic signed [33:0]   db;
  logic [33:0]          ma;
  logic [33:0]          mb;

  always_comb begin
    lane_next = '0;
    for (int i = 0; i < hlc_pkg::NUM_PLANES; i++) begin
      da = hlc_pkg::plane_dist(3'(i), in_a);
      db = hlc_pkg::plane_dist(3'(i), in_b);
      ma = da[33] ? 34'(-da) : 34'(da);
      mb = db[33] ? 34'(-db) : 34'(db);
      lane_next[i].rem = {2'b0, ma[32:1]};
      lane_next[i].quo = '0;
      lane_next[i].sum = ma + mb;
      lane_next[i].lsb = ma[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_seg.a  <= in_a;
      out_seg.b  <= in_b;
      out_seg.ca <= hlc_pkg::outcode(in_a);
      out_seg.cb <= hlc_pkg::outcode(in_b);
      out_lane   <= lane_next;
    end
  end

endmodule

/* rtl/hlc_divider.sv */
// pipelined restoring divider, six lanes, two quotient bits per stage
module hlc_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  hlc_pkg::seg_t         in_seg,
  input  hlc_pkg::lane_t [5:0]  in_lane,
  output logic                  out_valid,
  output hlc_pkg::seg_t         out_seg,
  output hlc_pkg::lane_t [5:0]  out_lane
);

  logic                 vld  [hlc_pkg::DIV_STAGES];
  hlc_pkg::seg_t        seg  [hlc_pkg::DIV_STAGES];
  hlc_pkg::lane_t [5:0] lane [hlc_pkg::DIV_STAGES];

  for (genvar s = 0; s < hlc_pkg::DIV_STAGES; s++) begin : g_stage
    logic                 vld_prev;
    hlc_pkg::seg_t        seg_prev;
    hlc_pkg::lane_t [5:0] lane_prev;
    hlc_pkg::lane_t [5:0] lane_next;
    hlc_pkg::step_t       st;

    if (s == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign seg_prev  = in_seg;
      assign lane_prev = in_lane;
    end else begin : g_rest
      assign vld_prev  = vld[s-1];
      assign seg_prev  = seg[s-1];
      assign lane_prev = lane[s-1];
    end

    always_comb begin
      lane_next = lane_prev;
      st        = '0;
      for (int i = 0; i < hlc_pkg::NUM_PLANES; i++) begin
        for (int k = 0; k < hlc_pkg::DIV_PER_STAGE; k++) begin
          st = hlc_pkg::div_step(lane_next[i].rem, lane_next[i].sum,
                                 (s == 0 && k == 0) ? lane_next[i].lsb : 1'b0);
          lane_next[i].rem = st.rem;
          lane_next[i].quo = {lane_next[i].quo[30:0], st.q};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        seg[s]  <= seg_prev;
        lane[s] <= lane_next;
      end
    end
  end

  assign out_valid = vld[hlc_pkg::DIV_STAGES-1];
  assign out_seg   = seg[hlc_pkg::DIV_STAGES-1];
  assign out_lane  = lane[hlc_pkg::DIV_STAGES-1];

endmodule

/* rtl/hlc_interp.sv */
// intersection points: multiply by the factor, round, then test the other planes
module hlc_interp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  hlc_pkg::seg_t         in_seg,
  input  hlc_pkg::lane_t [5:0]  in_lane,
  output logic                  out_valid,
  output hlc_pkg::seg_t         out_seg,
  output hlc_pkg::vtx_t [5:0]   out_pt,
  output logic [5:0]            out_ok
);

  logic                 mul_valid;
  hlc_pkg::seg_t        mul_seg;
  logic signed [65:0]   prod      [hlc_pkg::NUM_PLANES][hlc_pkg::NUM_COMP];
  logic signed [65:0]   prod_next [hlc_pkg::NUM_PLANES][hlc_pkg::NUM_COMP];
  logic [31:0]          alpha;
  logic signed [32:0]   diff;

  hlc_pkg::vtx_t [5:0]  pt_next;
  logic [5:0]           ok_next;
  logic signed [65:0]   rnd;
  logic signed [33:0]   res;
  logic signed [33:0]   d;
  logic [5:0]           mask;

  // multiply
  always_comb begin
    for (int i = 0; i < hlc_pkg::NUM_PLANES; i++) begin
      alpha = (in_lane[i].sum == '0) ? '0 : in_lane[i].quo;
      for (int c = 0; c < hlc_pkg::NUM_COMP; c++) begin
        diff = hlc_pkg::vtx_comp(in_seg.b, 3'(c)) - hlc_pkg::vtx_comp(in_seg.a, 3'(c));
        prod_next[i][c] = diff * $signed({1'b0, alpha});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_seg <= in_seg;
      prod    <= prod_next;
    end
  end

  // round, add and check
  always_comb begin
    pt_next = '0;
    ok_next = '0;
    mask    = mul_seg.ca | mul_seg.cb;
    for (int i = 0; i < hlc_pkg::NUM_PLANES; i++) begin
      for (int c = 0; c < hlc_pkg::NUM_COMP; c++) begin
        rnd = (prod[i][c] + 66'sd1073741824) >>> 31;
        res = 34'(hlc_pkg::vtx_comp(mul_seg.a, 3'(c))) + rnd[33:0];
        case (3'(c))
          hlc_pkg::COMP_X: pt_next[i].x     = res[31:0];
          hlc_pkg::COMP_Y: pt_next[i].y     = res[31:0];
          hlc_pkg::COMP_Z: pt_next[i].z     = res[31:0];
          hlc_pkg::COMP_W: pt_next[i].w     = res[31:0];
          default:         pt_next[i].level = res[15:0];
        endcase
      end
      ok_next[i] = mask[i];
      for (int j = 0; j < hlc_pkg::NUM_PLANES; j++) begin
        d = hlc_pkg::plane_dist(3'(j), pt_next[i]);
        if (j != i && d[33]) begin
          ok_next[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_seg <= mul_seg;
      out_pt  <= pt_next;
      out_ok  <= ok_next;
    end
  end

  for (genvar i = 0; i < hlc_pkg::NUM_PLANES; i++) begin : g_chk
    a_alpha_range: assert property (@(posedge clk) disable iff (rst)
      in_valid && in_lane[i].sum != '0 |-> in_lane[i].quo <= 32'h8000_0000)
      else $error("clip factor above one");
  end

  a_ok_in_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ok & ~(out_seg.ca | out_seg.cb)) == '0)
    else $error("point kept for a plane not crossed");

endmodule

/* rtl/hlc_select.sv */
// picks the first two kept points and builds the result register
module hlc_select (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  hlc_pkg::seg_t        in_seg,
  input  hlc_pkg::vtx_t [5:0]  in_pt,
  input  logic [5:0]           in_ok,
  output logic                 out_valid,
  output hlc_pkg::res_t        out_res
);

  hlc_pkg::res_t res_next;
  hlc_pkg::vtx_t first;
  hlc_pkg::vtx_t second;
  logic [1:0]    cnt;

  always_comb begin
    first  = '0;
    second = '0;
    cnt    = '0;
    for (int i = 0; i < hlc_pkg::NUM_PLANES; i++) begin
      if (in_ok[i] && cnt == 2'd0) begin
        first = in_pt[i];
        cnt   = 2'd1;
      end else if (in_ok[i] && cnt == 2'd1) begin
        second = in_pt[i];
        cnt    = 2'd2;
      end
    end

    res_next = '0;
    if ((in_seg.ca & in_seg.cb) != '0) begin
      res_next = '0;
    end else if ((in_seg.ca | in_seg.cb) == '0) begin
      res_next.visible = 1'b1;
      res_next.a       = in_seg.a;
      res_next.b       = in_seg.b;
    end else if (cnt == 2'd2) begin
      res_next.visible = 1'b1;
      res_next.a       = first;
      res_next.b       = second;
    end else if (cnt == 2'd1) begin
      res_next.visible = 1'b1;
      res_next.a       = (in_seg.ca == '0) ? in_seg.a : first;
      res_next.b       = (in_seg.ca == '0) ? first : in_seg.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res_next;
    end
  end

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.visible |-> out_res.a == '0 && out_res.b == '0)
    else $error("rejected segment carries nonzero fields");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    en && in_valid && (in_seg.ca & in_seg.cb) != '0 |=> !out_res.visible)
    else $error("trivially outside segment shown");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the homogeneous line clipper: directed and random segments
module testbench;

  localparam int N_RANDOM   = 1930;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    hlc_pkg::vtx_t a;
    hlc_pkg::vtx_t b;
  } segment_t;

  class clip_scoreboard;
    hlc_pkg::res_t expected_q[$];
    int   errors;
    int   n_visible;
    int   n_rejected;

    function longint plane_gap(int p, hlc_pkg::vtx_t v);
      longint x, y, z, w;
      x = v.x;
      y = v.y;
      z = v.z;
      w = v.w;
      case (p)
        hlc_pkg::PLANE_LEFT:   return x + w;
        hlc_pkg::PLANE_RIGHT:  return w - x;
        hlc_pkg::PLANE_BOTTOM: return y + w;
        hlc_pkg::PLANE_TOP:    return w - y;
        hlc_pkg::PLANE_FAR:    return w - z;
        default:               return z;
      endcase
    endfunction

    function bit [5:0] region(hlc_pkg::vtx_t v);
      bit [5:0] code;
      for (int i = 0; i < hlc_pkg::NUM_PLANES; i++) code[i] = plane_gap(i, v) < 0;
      return code;
    endfunction

    function longint lerp(longint a, longint b, longint alpha);
      longint p;
      p = (b - a) * alpha;
      return a + ((p + (longint'(1) <<< 30)) >>> 31);
    endfunction

    function hlc_pkg::res_t clip_segment(hlc_pkg::vtx_t a, hlc_pkg::vtx_t b);
      hlc_pkg::res_t r;
      hlc_pkg::vtx_t pts[2];
      hlc_pkg::vtx_t np;
      bit [5:0] ca, cb, crossed;
      longint da, db, alpha;
      longint unsigned ua, ub, sum;
      int count;
      bit ok;
      r = '0;
      count = 0;
      ca = region(a);
      cb = region(b);
      if ((ca & cb) != 0) return r;
      crossed = ca | cb;
      if (crossed == 0) begin
        r.visible = 1'b1;
        r.a = a;
        r.b = b;
        return r;
      end
      for (int i = 0; i < hlc_pkg::NUM_PLANES && count < 2; i++) begin
        if (!crossed[i]) continue;
        da = plane_gap(i, a);
        db = plane_gap(i, b);
        ua = da < 0 ? -da : da;
        ub = db < 0 ? -db : db;
        sum = ua + ub;
        alpha = sum != 0 ? longint'((ua << 31) / sum) : 0;
        np.x = 32'(lerp(a.x, b.x, alpha));
        np.y = 32'(lerp(a.y, b.y, alpha));
        np.z = 32'(lerp(a.z, b.z, alpha));
        np.w = 32'(lerp(a.w, b.w, alpha));
        np.level = 16'(lerp(longint'(a.level), longint'(b.level), alpha));
        ok = 1'b1;
        for (int j = 0; j < hlc_pkg::NUM_PLANES; j++)
          if (j != i && plane_gap(j, np) < 0) ok = 1'b0;
        if (ok) begin
          pts[count] = np;
          count++;
        end
      end
      if (count == 2) begin
        r.visible = 1'b1;
        r.a = pts[0];
        r.b = pts[1];
      end else if (count == 1) begin
        r.visible = 1'b1;
        r.a = ca == 0 ? a : pts[0];
        r.b = ca == 0 ? pts[0] : b;
      end
      return r;
    endfunction

    function void note_segment(hlc_pkg::vtx_t a, hlc_pkg::vtx_t b);
      expected_q.push_back(clip_segment(a, b));
    endfunction

    function void cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(hlc_pkg::res_t got);
      hlc_pkg::res_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with no segment outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (e.visible) n_visible++;
      else n_rejected++;
      cmp("visible", e.visible, got.visible);
      cmp("out_ax", e.a.x, got.a.x);
      cmp("out_ay", e.a.y, got.a.y);
      cmp("out_az", e.a.z, got.a.z);
      cmp("out_aw", e.a.w, got.a.w);
      cmp("out_a_level", e.a.level, got.a.level);
      cmp("out_bx", e.b.x, got.b.x);
      cmp("out_by", e.b.y, got.b.y);
      cmp("out_bz", e.b.z, got.b.z);
      cmp("out_bw", e.b.w, got.b.w);
      cmp("out_b_level", e.b.level, got.b.level);
    endfunction
  endclass

  logic clk;
  logic rst;
  hlc_seg_if seg ();
  hlc_res_if res ();

  homogeneous_line_clipper u_top (
    .clk(clk),
    .rst(rst),
    .seg(seg.sink),
    .res(res.source)
  );

  clip_scoreboard sb;
  segment_t stim_q[$];
  int  phase;
  int  n_sent;
  int  idle_cycles;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic hlc_pkg::vtx_t mk(real x, real y, real z, real w, int lvl);
    hlc_pkg::vtx_t v;
    v.x = 32'($rtoi(x * 65536.0));
    v.y = 32'($rtoi(y * 65536.0));
    v.z = 32'($rtoi(z * 65536.0));
    v.w = 32'($rtoi(w * 65536.0));
    v.level = 16'(lvl);
    return v;
  endfunction

  function automatic hlc_pkg::vtx_t flat(logic [31:0] c, logic [15:0] lvl);
    hlc_pkg::vtx_t v;
    v.x = c;
    v.y = c;
    v.z = c;
    v.w = c;
    v.level = lvl;
    return v;
  endfunction

  task automatic add(hlc_pkg::vtx_t a, hlc_pkg::vtx_t b);
    segment_t s;
    s.a = a;
    s.b = b;
    stim_q.push_back(s);
  endtask

  function automatic logic [31:0] near(int w);
    return 32'($urandom_range(0, 4 * w) - 2 * w);
  endfunction

  function automatic hlc_pkg::vtx_t rand_vtx(int w);
    hlc_pkg::vtx_t v;
    if ($urandom_range(0, 99) < 15) begin
      v.x = $urandom;
      v.y = $urandom;
      v.z = $urandom;
      v.w = $urandom;
    end else begin
      v.x = near(w);
      v.y = near(w);
      v.z = 32'($urandom_range(0, 3 * w) - w);
      v.w = $urandom_range(0, 9) == 0 ? 32'(-$urandom_range(0, w)) : 32'(w);
    end
    v.level = 16'($urandom);
    return v;
  endfunction

  task automatic build_stimulus();
    int w;
    // wholly inside, shared outside plane
    add(mk(0, 0, 0.5, 1, 100), mk(0.5, 0.5, 0.5, 1, 60000));
    add(mk(2, 0, 0.5, 1, 1), mk(3, 0.5, 0.5, 1, 2));
    // inside to outside across each plane
    add(mk(0, 0, 0.5, 1, 0), mk(-3, 0, 0.5, 1, 65535));
    add(mk(0, 0, 0.5, 1, 0), mk(3, 0, 0.5, 1, 65535));
    add(mk(0, 0, 0.5, 1, 65535), mk(0, -3, 0.5, 1, 0));
    add(mk(0, 0, 0.5, 1, 65535), mk(0, 3, 0.5, 1, 0));
    add(mk(0, 0, 0.5, 1, 1000), mk(0, 0, 4, 1, 5000));
    add(mk(0, 0, 0.5, 1, 1000), mk(0, 0, -2, 1, 5000));
    // outside to inside, through both sides, passing by the corner
    add(mk(-3, 0.2, 0.5, 1, 7), mk(0, 0, 0.5, 1, 9));
    add(mk(-2, 0.1, 0.3, 1, 0), mk(2, -0.1, 0.7, 1, 65535));
    add(mk(-3, 0, 0.5, 1, 0), mk(0, 3, 0.5, 1, 65535));
    add(mk(-2, 0.5, 0.5, 1, 0), mk(0.5, 2, 0.5, 1, 65535));
    add(mk(-2, -2, -1, 1, 3), mk(2, 2, 2, 1, 65000));
    add(mk(-2, 0, 0.5, 1, 0), mk(3, 0, 0.5, 3, 400));
    // extremes
    add(flat(32'h7fffffff, 16'hffff), flat(32'h80000000, 16'h0000));
    add(flat(32'h80000000, 16'h0000), flat(32'h7fffffff, 16'hffff));
    add(flat(32'h0, 16'h0), flat(32'h0, 16'hffff));
    add(flat(32'hffffffff, 16'hffff), flat(32'h1, 16'h1));
    add(mk(0, 0, 0, -1, 5), mk(0, 0, 0, 1, 6));
    begin
      hlc_pkg::vtx_t a, b;
      a = flat(32'h80000000, 16'hffff);
      a.w = 32'h7fffffff;
      a.z = 0;
      b = flat(32'h7fffffff, 16'h0);
      b.w = 32'h80000000;
      add(a, b);
      add(b, a);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      w = $urandom_range(0, 9) == 0 ? $urandom_range(1, 32'h3fffffff)
                                    : $urandom_range(1, 8) << 16;
      add(rand_vtx(w), rand_vtx(w));
    end
  endtask

  task automatic drive_segments();
    int sender_idle;
    for (int i = 0; i < stim_q.size(); i++) begin
      phase = i < stim_q.size() / 3 ? 0 : (i < 2 * stim_q.size() / 3 ? 1 : 2);
      sender_idle = phase == 0 ? 28 : (phase == 1 ? 82 : 0);
      while ($urandom_range(0, 99) < sender_idle) begin
        seg.valid <= 1'b0;
        @(posedge clk);
      end
      seg.valid   <= 1'b1;
      seg.ax      <= stim_q[i].a.x;
      seg.ay      <= stim_q[i].a.y;
      seg.az      <= stim_q[i].a.z;
      seg.aw      <= stim_q[i].a.w;
      seg.a_level <= stim_q[i].a.level;
      seg.bx      <= stim_q[i].b.x;
      seg.by      <= stim_q[i].b.y;
      seg.bz      <= stim_q[i].b.z;
      seg.bw      <= stim_q[i].b.w;
      seg.b_level <= stim_q[i].b.level;
      @(posedge clk);
      while (!seg.ready) @(posedge clk);
    end
    seg.valid <= 1'b0;
  endtask

  initial begin
    bit held;
    int recv_idle;
    held = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !held && !rst) begin
        held = 1'b1;
        res.ready <= 1'b0;
        for (int k = 1; k < HOLD_LEN; k++) @(posedge clk);
      end else begin
        recv_idle = phase == 0 ? 82 : (phase == 1 ? 28 : 0);
        res.ready <= $urandom_range(0, 99) >= recv_idle;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && seg.valid && seg.ready) begin
      sb.note_segment('{seg.ax, seg.ay, seg.az, seg.aw, seg.a_level},
                      '{seg.bx, seg.by, seg.bz, seg.bw, seg.b_level});
      n_sent++;
    end
  end

  always @(posedge clk) begin
    hlc_pkg::res_t got;
    if (!rst && res.valid && res.ready) begin
      got.visible = res.visible;
      got.a = '{res.out_ax, res.out_ay, res.out_az, res.out_aw, res.out_a_level};
      got.b = '{res.out_bx, res.out_by, res.out_bz, res.out_bw, res.out_b_level};
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (seg.valid && seg.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transaction for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    phase = 0;
    rst = 1'b1;
    seg.valid = 1'b0;
    seg.ax = '0;
    seg.ay = '0;
    seg.az = '0;
    seg.aw = '0;
    seg.a_level = '0;
    seg.bx = '0;
    seg.by = '0;
    seg.bz = '0;
    seg.bw = '0;
    seg.b_level = '0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drive_segments();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d segments clipped under three stall mixes and one long output hold",
             n_sent);
    $display("%0d visible and %0d rejected results compared field by field",
             sb.n_visible, sb.n_rejected);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
